// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the modules that carry checks.
// Each macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("eligibility trace table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ETT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("eligibility trace table: next-cycle check failed");

`endif

// ----- hdl/ett_pkg.sv -----
package ett_pkg;

  localparam int unsigned TRACE_W   = 24;
  localparam int unsigned DECAY_W   = 16;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned INDEX_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [TRACE_W-1:0] ONE_Q816 = 24'h010000;
  localparam logic [TRACE_W-1:0] MAX_Q816 = 24'hFFFFFF;

  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd58982;
  localparam logic [TRACE_W-1:0] PRUNE_RESET = 24'd655;

  typedef enum logic [CMD_W-1:0] {
    CMD_DECAY = 3'd0,
    CMD_VISIT = 3'd1,
    CMD_PRUNE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY_RATE      = 1'b0,
    CFG_PRUNE_THRESHOLD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] state_index;
    logic               replacing;
  } in_item_t;

  typedef struct packed {
    logic [TRACE_W-1:0] trace_value;
    logic               present;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic sweep_step;
    logic sweep_clear;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/eligibility_trace_table.sv -----
// Channel   Direction  Handshake                   Payload
// input     in         in_valid_i / in_ready_o     in_i  (cmd, state_index, replacing)
// output    out        out_valid_o / out_ready_i   out_o (trace_value, present)
// config    in         cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// A read or a visit is looked up through the registered read port of the table RAM and its
// result is then registered at the output. Decay, prune and clear all walk the table one
// entry per cycle, and decay and prune end with a drain state for the last write-back.
// After reset a clearing pass over every table entry runs before the first transaction is taken.
// A stalled output holds its result while the next transaction is accepted and processed.
module eligibility_trace_table #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ett_pkg::in_item_t             in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ett_pkg::out_item_t            out_o,
  input  logic                          cfg_we_i,
  input  logic [ett_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ett_pkg::TRACE_W-1:0]   cfg_wdata_i
);

  `include "assert_macros.svh"

  ett_pkg::ctl_t ctl;
  ett_pkg::sts_t sts;

  ett_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ett_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  `ETT_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)
  `ETT_ASSERT_SAME(a_commit_slot_free, ctl.commit, !out_valid_o || out_ready_i)
  `ETT_ASSERT_SAME(a_present_matches, out_valid_o, out_o.present == (out_o.trace_value != '0))
  `ETT_ASSERT_SAME(a_no_sweep_when_ready, in_ready_o, !ctl.sweep_step)

endmodule

// ----- hdl/ett_ram.sv -----
module ett_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/ett_ctrl.sv -----
module ett_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [ett_pkg::CMD_W-1:0]    in_cmd_i,
  output logic                         in_ready_o,
  input  ett_pkg::sts_t                sts_i,
  output ett_pkg::ctl_t                ctl_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_CLEAR,
    ST_DRAIN,
    ST_RESPOND
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        ctl_o.sweep_step  = 1'b1;
        ctl_o.sweep_clear = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          case (in_cmd_i) inside
            ett_pkg::CMD_DECAY, ett_pkg::CMD_PRUNE: state_d = ST_SWEEP;
            ett_pkg::CMD_CLEAR:                     state_d = ST_CLEAR;
            default:                                state_d = ST_RESPOND;
          endcase
        end
      end
      ST_SWEEP: begin
        ctl_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_CLEAR: begin
        ctl_o.sweep_step  = 1'b1;
        ctl_o.sweep_clear = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_RESPOND;
        end
      end
      ST_DRAIN: begin
        state_d = ST_RESPOND;
      end
      ST_RESPOND: begin
        if (sts_i.out_free) begin
          ctl_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      in_ready_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

// ----- hdl/ett_datapath.sv -----
module ett_datapath #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ett_pkg::in_item_t                 in_i,
  input  logic                              cfg_we_i,
  input  logic [ett_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ett_pkg::TRACE_W-1:0]       cfg_wdata_i,
  input  ett_pkg::ctl_t                     ctl_i,
  output ett_pkg::sts_t                     sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ett_pkg::out_item_t                out_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned TW = ett_pkg::TRACE_W;
  localparam int unsigned DW = ett_pkg::DECAY_W;

  logic [ett_pkg::CMD_W-1:0] cmd_q;
  logic [AW-1:0]             idx_q;
  logic                      in_rng_q;
  logic                      repl_q;

  logic [AW-1:0]             swp_addr_q;
  logic                      wr_pend_q;
  logic [AW-1:0]             wr_addr_q;

  logic [DW-1:0]             decay_q;
  logic [TW-1:0]             prune_q;

  logic                      out_valid_q;
  ett_pkg::out_item_t        out_q;

  logic                      in_rng;
  logic                      sweep_last;
  logic                      sweep_rd;
  logic [TW-1:0]             rd_data;
  logic [TW+DW-1:0]          prod;
  logic [TW:0]               acc_sum;
  logic [TW-1:0]             visit_val;
  logic [TW-1:0]             sweep_val;
  logic [TW-1:0]             res_val;
  logic                      visit_wr;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [TW-1:0]             ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;

  assign in_rng     = ({24'b0, in_i.state_index} < 32'(TABLE_DEPTH));
  assign sweep_last = (swp_addr_q == AW'(TABLE_DEPTH - 1));
  assign sweep_rd   = ctl_i.sweep_step && !ctl_i.sweep_clear;

  assign prod      = (TW+DW)'(rd_data) * (TW+DW)'(decay_q);
  assign sweep_val = (cmd_q == ett_pkg::CMD_DECAY) ? prod[TW+DW-1:DW] :
                     ((rd_data < prune_q) ? '0 : rd_data);

  assign acc_sum   = {1'b0, rd_data} + {1'b0, ett_pkg::ONE_Q816};
  assign visit_val = repl_q ? ett_pkg::ONE_Q816 :
                     (acc_sum[TW] ? ett_pkg::MAX_Q816 : acc_sum[TW-1:0]);

  assign visit_wr = ctl_i.commit && in_rng_q && (cmd_q == ett_pkg::CMD_VISIT);

  always_comb begin
    res_val = '0;
    if (in_rng_q) begin
      if (cmd_q == ett_pkg::CMD_VISIT) begin
        res_val = visit_val;
      end else if (cmd_q == ett_pkg::CMD_READ) begin
        res_val = rd_data;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_q;
    ram_wdata = sweep_val;
    if (wr_pend_q) begin
      ram_we = 1'b1;
    end else if (ctl_i.sweep_step && ctl_i.sweep_clear) begin
      ram_we    = 1'b1;
      ram_waddr = swp_addr_q;
      ram_wdata = '0;
    end else if (visit_wr) begin
      ram_we    = 1'b1;
      ram_waddr = idx_q;
      ram_wdata = visit_val;
    end
  end

  assign ram_re    = ctl_i.load || sweep_rd;
  assign ram_raddr = ctl_i.load ? AW'(in_i.state_index) : swp_addr_q;

  ett_ram #(
    .WIDTH (TW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q    <= in_i.cmd;
      idx_q    <= AW'(in_i.state_index);
      in_rng_q <= in_rng;
      repl_q   <= in_i.replacing;
    end
    if (sweep_rd) begin
      wr_addr_q <= swp_addr_q;
    end
    if (ctl_i.commit) begin
      out_q.trace_value <= res_val;
      out_q.present     <= (res_val != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swp_addr_q  <= '0;
      wr_pend_q   <= 1'b0;
      decay_q     <= ett_pkg::DECAY_RESET;
      prune_q     <= ett_pkg::PRUNE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      wr_pend_q <= sweep_rd;
      if (ctl_i.sweep_step) begin
        swp_addr_q <= sweep_last ? '0 : swp_addr_q + AW'(1);
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ett_pkg::CFG_DECAY_RATE:      decay_q <= cfg_wdata_i[DW-1:0];
          ett_pkg::CFG_PRUNE_THRESHOLD: prune_q <= cfg_wdata_i;
          default:                      ;
        endcase
      end
      if (ctl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.sweep_last = sweep_last;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_o            = out_q;

endmodule

// ----- dv/eligibility_trace_table_tb.sv -----
module eligibility_trace_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [ett_pkg::CMD_W-1:0]                   cmd_word_t;
  typedef logic [ett_pkg::INDEX_W-1:0]                 index_t;
  typedef logic [ett_pkg::TRACE_W-1:0]                 trace_t;
  typedef logic [ett_pkg::DECAY_W-1:0]                 rate_t;
  typedef logic [ett_pkg::TRACE_W+ett_pkg::DECAY_W-1:0] product_t;
  typedef logic [ett_pkg::TRACE_W:0]                   wide_sum_t;

  localparam int unsigned DEPTH = 256;
  localparam int RANDOM_ITEMS = 800;
  localparam int CMD_MAX = (1 << ett_pkg::CMD_W) - 1;
  localparam int IDX_MAX = (1 << ett_pkg::INDEX_W) - 1;
  localparam cmd_word_t CMD_UNUSED_LO = cmd_word_t'(ett_pkg::CMD_CLEAR + 1);
  localparam cmd_word_t CMD_UNUSED_HI = cmd_word_t'(CMD_MAX);
  localparam int SATURATE_VISITS = 258;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ett_pkg::in_item_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ett_pkg::out_item_t out_o;
  logic cfg_we_i = 1'b0;
  logic [ett_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  trace_t cfg_wdata_i = '0;

  eligibility_trace_table #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_i(in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o(out_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Shadow copy of the trace table and its settings.
  trace_t trace_mem [DEPTH] = '{default: '0};
  rate_t decay_factor = ett_pkg::DECAY_RESET;
  trace_t prune_level = ett_pkg::PRUNE_RESET;

  ett_pkg::in_item_t pending_items[$];
  ett_pkg::out_item_t trace_expect[$];

  logic in_fire = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_left = 0;
  int queued_cnt = 0;
  int fail_cnt = 0;
  int results_cnt = 0;
  int phase_cnt = 0;
  int visit_cnt = 0;
  int saturate_cnt = 0;
  int read_cnt = 0;
  int sweep_cnt = 0;
  int unused_cnt = 0;

  function automatic ett_pkg::out_item_t trace_step(ett_pkg::in_item_t item);
    ett_pkg::out_item_t res;
    product_t prod;
    wide_sum_t sum;
    logic hit;
    res = '0;
    hit = int'(item.state_index) < DEPTH;
    case (item.cmd)
      ett_pkg::CMD_DECAY: begin
        sweep_cnt++;
        for (int i = 0; i < DEPTH; i++) begin
          prod = product_t'(trace_mem[i]) * product_t'(decay_factor);
          trace_mem[i] = prod[ett_pkg::TRACE_W+ett_pkg::DECAY_W-1:ett_pkg::DECAY_W];
        end
      end
      ett_pkg::CMD_VISIT: begin
        visit_cnt++;
        if (hit) begin
          if (item.replacing) begin
            res.trace_value = ett_pkg::ONE_Q816;
          end else begin
            sum = wide_sum_t'(trace_mem[item.state_index]) + wide_sum_t'(ett_pkg::ONE_Q816);
            if (sum[ett_pkg::TRACE_W]) saturate_cnt++;
            res.trace_value = sum[ett_pkg::TRACE_W] ? ett_pkg::MAX_Q816 :
                                                     sum[ett_pkg::TRACE_W-1:0];
          end
          trace_mem[item.state_index] = res.trace_value;
        end
      end
      ett_pkg::CMD_PRUNE: begin
        sweep_cnt++;
        for (int i = 0; i < DEPTH; i++) begin
          if (trace_mem[i] < prune_level) trace_mem[i] = '0;
        end
      end
      ett_pkg::CMD_READ: begin
        read_cnt++;
        if (hit) res.trace_value = trace_mem[item.state_index];
      end
      ett_pkg::CMD_CLEAR: begin
        sweep_cnt++;
        for (int i = 0; i < DEPTH; i++) trace_mem[i] = '0;
      end
      default: begin
        unused_cnt++;
      end
    endcase
    res.present = |res.trace_value;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    if (fail_cnt < 10) $display("%0t: %s", $time, what);
    fail_cnt++;
  endtask

  task automatic push_item(cmd_word_t c, index_t idx, logic repl);
    ett_pkg::in_item_t item;
    item.cmd = c;
    item.state_index = idx;
    item.replacing = repl;
    pending_items.push_back(item);
    queued_cnt++;
  endtask

  // Table-wide commands ignore the index and mode, so those carry random content.
  task automatic push_sweep(cmd_word_t c);
    push_item(c, index_t'($urandom_range(0, IDX_MAX)), 1'($urandom_range(0, 1)));
  endtask

  function automatic index_t pick_index();
    if ($urandom_range(0, 4) != 0) return index_t'($urandom_range(0, 7));
    return index_t'($urandom_range(0, IDX_MAX));
  endfunction

  task automatic write_cfg(ett_pkg::cfg_idx_e which, trace_t value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= which;
    cfg_wdata_i <= value;
    if (which == ett_pkg::CFG_DECAY_RATE) decay_factor = value[ett_pkg::DECAY_W-1:0];
    else prune_level = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(rate_t rate, trace_t level);
    trace_t rate_word;
    rate_word = {index_t'($urandom_range(0, IDX_MAX)), rate};
    write_cfg(ett_pkg::CFG_DECAY_RATE, rate_word);
    write_cfg(ett_pkg::CFG_PRUNE_THRESHOLD, level);
    phase_cnt++;
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || trace_expect.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // One learning step: decay, a few visits, a few reads, then prune.
  // Now and then a step is broken off or followed by arbitrary commands.
  task automatic add_episode();
    int n;
    if ($urandom_range(0, 9) != 0) push_sweep(ett_pkg::CMD_DECAY);
    n = $urandom_range(1, 6);
    repeat (n) push_item(ett_pkg::CMD_VISIT, pick_index(), $urandom_range(0, 3) == 0);
    n = $urandom_range(0, 3);
    repeat (n) push_item(ett_pkg::CMD_READ, pick_index(), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) != 0) push_sweep(ett_pkg::CMD_PRUNE);
    if ($urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        push_item(cmd_word_t'($urandom_range(0, CMD_MAX)), index_t'($urandom_range(0, IDX_MAX)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(0, 5) == 0) begin
          burst_left = $urandom_range(40, 100);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            out_ready_i <= 1'b0;
            stall_left = $urandom_range(1, 10);
          end
          1: begin
            out_ready_i <= 1'b1;
            stall_left = $urandom_range(40, 120);
          end
          default: begin
            out_ready_i <= 1'b1;
            stall_left = $urandom_range(0, 6);
          end
        endcase
      end
    end
  end

  // The result is checked before the prediction for a transaction taken on the same edge.
  always @(posedge clk_i) begin
    ett_pkg::out_item_t want;
    if (rst_ni) begin
      in_fire <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        results_cnt++;
        if (trace_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected result trace_value=%h present=%b",
                                    out_o.trace_value, out_o.present));
        end else begin
          want = trace_expect.pop_front();
          if (out_o.trace_value !== want.trace_value || out_o.present !== want.present) begin
            report_mismatch($sformatf(
              "result mismatch: expected trace_value=%h present=%b, got trace_value=%h present=%b",
              want.trace_value, want.present, out_o.trace_value, out_o.present));
          end
        end
      end
      if (in_valid_i && in_ready_o) trace_expect.push_back(trace_step(in_i));
    end
  end

  initial begin
    int directed_cnt;
    int phase_goal;
    int rnd_phase;
    index_t hot_index;
    rnd_phase = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_config(16'hFFFF, '0);
    push_item(ett_pkg::CMD_READ, 8'd0, 1'b0);
    push_item(ett_pkg::CMD_VISIT, 8'd0, 1'b0);
    push_item(ett_pkg::CMD_VISIT, 8'd0, 1'b0);
    push_item(ett_pkg::CMD_VISIT, 8'd0, 1'b1);
    push_item(ett_pkg::CMD_VISIT, index_t'(IDX_MAX), 1'b1);
    push_item(ett_pkg::CMD_READ, index_t'(IDX_MAX), 1'b1);
    push_sweep(ett_pkg::CMD_DECAY);
    push_item(ett_pkg::CMD_READ, 8'd0, 1'b0);
    push_sweep(ett_pkg::CMD_PRUNE);
    push_item(ett_pkg::CMD_READ, 8'd0, 1'b1);
    push_item(CMD_UNUSED_LO, 8'd0, 1'b1);
    push_item(CMD_UNUSED_HI, index_t'(IDX_MAX), 1'b0);
    push_sweep(ett_pkg::CMD_CLEAR);
    push_item(ett_pkg::CMD_READ, index_t'(IDX_MAX), 1'b0);
    wait_idle();

    set_config('0, ett_pkg::MAX_Q816);
    push_item(ett_pkg::CMD_VISIT, 8'd200, 1'b0);
    push_sweep(ett_pkg::CMD_DECAY);
    push_item(ett_pkg::CMD_READ, 8'd200, 1'b0);
    push_item(ett_pkg::CMD_VISIT, 8'd17, 1'b1);
    push_item(ett_pkg::CMD_VISIT, 8'd17, 1'b0);
    push_sweep(ett_pkg::CMD_PRUNE);
    push_item(ett_pkg::CMD_READ, 8'd17, 1'b0);
    push_item(cmd_word_t'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
              index_t'($urandom_range(0, IDX_MAX)), 1'b1);
    directed_cnt = queued_cnt;

    while (queued_cnt < directed_cnt + RANDOM_ITEMS) begin
      wait_idle();
      case (rnd_phase)
        0: set_config(ett_pkg::DECAY_RESET, ett_pkg::PRUNE_RESET);
        1: set_config(16'hFFFF, '0);
        2: set_config('0, ett_pkg::MAX_Q816);
        3: set_config(16'h8000, ett_pkg::ONE_Q816);
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            set_config(rate_t'($urandom), trace_t'($urandom_range(0, 24'h020000)));
          end else begin
            set_config(rate_t'($urandom), trace_t'($urandom_range(0, ett_pkg::MAX_Q816)));
          end
        end
      endcase
      if (rnd_phase == 1) begin
        // Enough accumulating visits to one entry to drive it into saturation.
        hot_index = index_t'($urandom_range(0, IDX_MAX));
        repeat (SATURATE_VISITS) push_item(ett_pkg::CMD_VISIT, hot_index, 1'b0);
        push_item(ett_pkg::CMD_READ, hot_index, 1'b0);
      end
      phase_goal = queued_cnt + $urandom_range(80, 160);
      while (queued_cnt < phase_goal) add_episode();
      rnd_phase++;
    end

    wait_idle();
    repeat (DEPTH + 8) @(posedge clk_i);
    if (trace_expect.size() != 0) begin
      $display("%0d expected results never arrived", trace_expect.size());
      fail_cnt += trace_expect.size();
    end
    $display("Checked %0d results over %0d register settings: %0d visits (%0d saturating),",
             results_cnt, phase_cnt, visit_cnt, saturate_cnt);
    $display("%0d reads, %0d table-wide sweeps, %0d unused command codes; %0d mismatches.",
             read_cnt, sweep_cnt, unused_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
